>>> rtl/core/tf_pkg.sv
// Twofish package: types, constants and the q, MDS, RS and h functions
`timescale 1ns / 1ps
package tf_pkg;

  localparam int unsigned RoundCount  = 16;
  localparam int unsigned SubkeyStep  = 32'h0101_0101;
  localparam int unsigned SubkeyCount = 8 + 2 * RoundCount;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 64;
  localparam logic [8:0]  RsPoly      = 9'h14d;
  localparam logic [8:0]  MdsPoly     = 9'h169;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_WORD_0 = 2'd0,
    REG_KEY_WORD_1 = 2'd1,
    REG_KEY_WORD_2 = 2'd2,
    REG_KEY_WORD_3 = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_low;
    logic [63:0] block_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } out_item_t;

  // one beat travelling along the round chain
  typedef struct packed {
    logic         valid;
    logic         mode;
    logic [127:0] x;
  } cell_beat_t;

  typedef logic [3:0] nib_tab_t [16];

  localparam nib_tab_t QaT0 = '{4'd8,4'd1,4'd7,4'd13,4'd6,4'd15,4'd3,4'd2,
                                4'd0,4'd11,4'd5,4'd9,4'd14,4'd12,4'd10,4'd4};
  localparam nib_tab_t QaT1 = '{4'd14,4'd12,4'd11,4'd8,4'd1,4'd2,4'd3,4'd5,
                                4'd15,4'd4,4'd10,4'd6,4'd7,4'd0,4'd9,4'd13};
  localparam nib_tab_t QaT2 = '{4'd11,4'd10,4'd5,4'd14,4'd6,4'd13,4'd9,4'd0,
                                4'd12,4'd8,4'd15,4'd3,4'd2,4'd4,4'd7,4'd1};
  localparam nib_tab_t QaT3 = '{4'd13,4'd7,4'd15,4'd4,4'd1,4'd2,4'd6,4'd14,
                                4'd9,4'd11,4'd3,4'd0,4'd8,4'd5,4'd12,4'd10};
  localparam nib_tab_t QbT0 = '{4'd2,4'd8,4'd11,4'd13,4'd15,4'd7,4'd6,4'd14,
                                4'd3,4'd1,4'd9,4'd4,4'd0,4'd10,4'd12,4'd5};
  localparam nib_tab_t QbT1 = '{4'd1,4'd14,4'd2,4'd11,4'd4,4'd12,4'd3,4'd7,
                                4'd6,4'd13,4'd10,4'd5,4'd15,4'd9,4'd0,4'd8};
  localparam nib_tab_t QbT2 = '{4'd4,4'd12,4'd7,4'd5,4'd1,4'd6,4'd9,4'd10,
                                4'd0,4'd14,4'd13,4'd8,4'd2,4'd11,4'd3,4'd15};
  localparam nib_tab_t QbT3 = '{4'd11,4'd9,4'd5,4'd1,4'd12,4'd3,4'd13,4'd14,
                                4'd6,4'd4,4'd7,4'd15,4'd2,4'd0,4'd8,4'd10};

  function automatic logic [3:0] ror4(input logic [3:0] v);
    ror4 = {v[0], v[3:1]};
  endfunction

  function automatic logic [7:0] q_perm(input logic [7:0] x, input logic sel_b);
    logic [3:0] a0, b0, a1, b1, a2, b2, a3, b3, a4, b4;
    a0 = x[7:4];
    b0 = x[3:0];
    a1 = a0 ^ b0;
    b1 = a0 ^ ror4(b0) ^ {a0[0], 3'b000};
    a2 = sel_b ? QbT0[a1] : QaT0[a1];
    b2 = sel_b ? QbT1[b1] : QaT1[b1];
    a3 = a2 ^ b2;
    b3 = a2 ^ ror4(b2) ^ {a2[0], 3'b000};
    a4 = sel_b ? QbT2[a3] : QaT2[a3];
    b4 = sel_b ? QbT3[b3] : QaT3[b3];
    q_perm = {b4, a4};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] poly);
    logic [8:0] aa;
    logic [7:0] acc;
    aa  = {1'b0, a};
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ aa[7:0];
      aa = {aa[7:0], 1'b0};
      if (aa[8]) aa = aa ^ poly;
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] mds_coef(input int unsigned r, input int unsigned c);
    logic [7:0] m [4][4];
    m = '{'{8'h01,8'hEF,8'h5B,8'h5B}, '{8'h5B,8'hEF,8'hEF,8'h01},
          '{8'hEF,8'h5B,8'h01,8'hEF}, '{8'hEF,8'h01,8'hEF,8'h5B}};
    mds_coef = m[r][c];
  endfunction

  function automatic logic [7:0] rs_coef(input int unsigned r, input int unsigned c);
    logic [7:0] m [4][8];
    m = '{'{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
          '{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
          '{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
          '{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}};
    rs_coef = m[r][c];
  endfunction

  // key-dependent S-box layer followed by the MDS mix
  function automatic logic [31:0] h_fun(input logic [31:0] x, input logic [127:0] l);
    logic [7:0] y [4];
    logic [7:0] v;
    logic [31:0] z;
    for (int j = 0; j < 4; j++) y[j] = x[8*j +: 8];
    y[0] = q_perm(y[0], 1'b1) ^ l[96 +: 8];
    y[1] = q_perm(y[1], 1'b0) ^ l[104 +: 8];
    y[2] = q_perm(y[2], 1'b0) ^ l[112 +: 8];
    y[3] = q_perm(y[3], 1'b1) ^ l[120 +: 8];
    y[0] = q_perm(y[0], 1'b1) ^ l[64 +: 8];
    y[1] = q_perm(y[1], 1'b1) ^ l[72 +: 8];
    y[2] = q_perm(y[2], 1'b0) ^ l[80 +: 8];
    y[3] = q_perm(y[3], 1'b0) ^ l[88 +: 8];
    y[0] = q_perm(y[0], 1'b0) ^ l[32 +: 8];
    y[1] = q_perm(y[1], 1'b1) ^ l[40 +: 8];
    y[2] = q_perm(y[2], 1'b0) ^ l[48 +: 8];
    y[3] = q_perm(y[3], 1'b1) ^ l[56 +: 8];
    y[0] = q_perm(y[0], 1'b0) ^ l[0 +: 8];
    y[1] = q_perm(y[1], 1'b0) ^ l[8 +: 8];
    y[2] = q_perm(y[2], 1'b1) ^ l[16 +: 8];
    y[3] = q_perm(y[3], 1'b1) ^ l[24 +: 8];
    y[0] = q_perm(y[0], 1'b1);
    y[1] = q_perm(y[1], 1'b0);
    y[2] = q_perm(y[2], 1'b1);
    y[3] = q_perm(y[3], 1'b0);
    z = '0;
    for (int j = 0; j < 4; j++) begin
      v = '0;
      for (int k = 0; k < 4; k++) v = v ^ gf_mul(mds_coef(j, k), y[k], MdsPoly);
      z[8*j +: 8] = v;
    end
    h_fun = z;
  endfunction

  // one RS word from two key words (low word first)
  function automatic logic [31:0] rs_word(input logic [63:0] m);
    logic [7:0] acc;
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 8; k++) acc = acc ^ gf_mul(rs_coef(j, k), m[8*k +: 8], RsPoly);
      w[8*j +: 8] = acc;
    end
    rs_word = w;
  endfunction

endpackage

>>> rtl/core/tf_key_sched.sv
// Key schedule: RS words at once, then a sweep of one subkey pair per cycle
`timescale 1ns / 1ps
module tf_key_sched #(
  parameter int unsigned ROUND_COUNT = tf_pkg::RoundCount
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [tf_pkg::CfgIdxW-1:0]              cfg_idx_i,
  input  logic [tf_pkg::CfgDataW-1:0]             cfg_data_i,
  output logic [8+2*ROUND_COUNT-1:0][31:0]        subkey_o,
  output logic [127:0]                            sbox_key_o,
  output logic                                    busy_o
);
  import tf_pkg::*;

  localparam int unsigned SkN   = 8 + 2 * ROUND_COUNT;
  localparam int unsigned Pairs = SkN / 2;
  localparam int unsigned CntW  = $clog2(Pairs + 1);

  logic [3:0][63:0]               key_q, key_d;
  logic [SkN-1:0][31:0]           sk_q;
  logic [127:0]                   sbk_q;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [CntW:0]                  sk_even, sk_odd;
  logic [127:0]                   even_w, odd_w;
  logic [31:0]                    ha, hb, hbr, sum1, sa, sb;

  always_comb begin
    key_d = key_q;
    cnt_d = cnt_q;
    if (cnt_q != CntW'(Pairs)) cnt_d = cnt_q + 1'b1;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_WORD_0: key_d[0] = cfg_data_i;
        REG_KEY_WORD_1: key_d[1] = cfg_data_i;
        REG_KEY_WORD_2: key_d[2] = cfg_data_i;
        REG_KEY_WORD_3: key_d[3] = cfg_data_i;
        default:        key_d = key_q;
      endcase
      cnt_d = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      even_w[32*i +: 32] = key_q[i][31:0];
      odd_w[32*i +: 32]  = key_q[i][63:32];
    end
    sk_even = {cnt_q, 1'b0};
    sk_odd  = {cnt_q, 1'b1};
    sa = SubkeyStep * (32'(cnt_q) * 2);
    sb = sa + SubkeyStep;
    ha = h_fun(sa, even_w);
    hbr = h_fun(sb, odd_w);
    hb = {hbr[23:0], hbr[31:24]};
    sum1 = ha + {hb[30:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      cnt_q <= '0;
    end else begin
      key_q <= key_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) sbk_q[32*(3-i) +: 32] <= rs_word(key_q[i]);
    if (cnt_q != CntW'(Pairs)) begin
      sk_q[sk_even] <= ha + hb;
      sk_q[sk_odd]  <= {sum1[22:0], sum1[31:23]};
    end
  end

  assign subkey_o   = sk_q;
  assign sbox_key_o = sbk_q;
  assign busy_o     = cfg_we_i || (cnt_q != CntW'(Pairs));

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Pairs)) else $error("sweep count out of range");
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> cnt_q == '0) else $error("key write did not restart sweep");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_we_i && cnt_q != CntW'(Pairs)) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("sweep stalled");
`endif
endmodule

>>> rtl/core/tf_round_cell.sv
// One Feistel round cell of the unrolled chain, either direction
`timescale 1ns / 1ps
module tf_round_cell #(
  parameter int unsigned RoundIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tf_pkg::cell_beat_t  beat_i,
  input  logic [127:0]        sbox_key_i,
  input  logic [31:0]         k_enc0_i,
  input  logic [31:0]         k_enc1_i,
  input  logic [31:0]         k_dec0_i,
  input  logic [31:0]         k_dec1_i,
  output tf_pkg::cell_beat_t  beat_o
);
  import tf_pkg::*;

  // encrypt cell i runs round i, decrypt cell i runs round 15-i; source and target halves alternate per round
  localparam bit EncOdd = RoundIdx[0];

  logic [31:0]  s0, s1, d0, d1, t0, t1, f0, f1, k0, k1, n0, n1, e0, e1;
  logic         odd;
  logic         valid_q, mode_q;
  logic [127:0] x_q;

  always_comb begin
    odd = beat_i.mode ? ~EncOdd : EncOdd;
    s0 = odd ? beat_i.x[95:64]  : beat_i.x[31:0];
    s1 = odd ? beat_i.x[127:96] : beat_i.x[63:32];
    d0 = odd ? beat_i.x[31:0]   : beat_i.x[95:64];
    d1 = odd ? beat_i.x[63:32]  : beat_i.x[127:96];
    k0 = beat_i.mode ? k_dec0_i : k_enc0_i;
    k1 = beat_i.mode ? k_dec1_i : k_enc1_i;
    t0 = h_fun(s0, sbox_key_i);
    t1 = h_fun({s1[23:0], s1[31:24]}, sbox_key_i);
    f0 = t0 + t1 + k0;
    f1 = t0 + {t1[30:0], 1'b0} + k1;
    e0 = d0 ^ f0;
    e1 = d1 ^ f1;
    if (!beat_i.mode) begin
      n0 = {e0[0], e0[31:1]};
      n1 = {d1[30:0], d1[31]} ^ f1;
    end else begin
      n0 = {d0[30:0], d0[31]} ^ f0;
      n1 = {e1[0], e1[31:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= beat_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q <= beat_i.mode;
      if (odd) x_q <= {s1, s0, n1, n0};
      else     x_q <= {n1, n0, s1, s0};
    end
  end

  assign beat_o = {valid_q, mode_q, x_q};
endmodule

>>> rtl/core/twofish_block_cipher.sv
// Twofish-256 top level: key schedule, whitening and a chain of 16 round cells
// Pipeline: a whitening register, 16 round cells and an output register from input beat to result beat.
// Throughput: one block per cycle; the chain stalls as a whole when the output stalls.
// Key write: each write restarts the sweep of all 20 subkey pairs; inputs are held off until it ends.
// Reset: asynchronous, active low; clears valids and loads the all-zero key.
`timescale 1ns / 1ps
module twofish_block_cipher #(
  parameter int unsigned ROUND_COUNT = tf_pkg::RoundCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tf_pkg::in_item_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tf_pkg::out_item_t             out_data_o
);
  import tf_pkg::*;

  localparam int unsigned SkN = 8 + 2 * ROUND_COUNT;

  logic [SkN-1:0][31:0] sk;
  logic [127:0]         sbk;
  logic                 ks_busy, en;
  cell_beat_t           chain [ROUND_COUNT+1];
  logic                 w_valid_q, w_mode_q;
  logic [127:0]         w_x_q;
  logic [127:0]         c, x;
  out_item_t            res;

  tf_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_ks (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .subkey_o(sk), .sbox_key_o(sbk), .busy_o(ks_busy)
  );

  // whole chain advances together unless a finished beat is stuck at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en || ks_busy;

  always_comb begin
    c = {in_data_i.block_high, in_data_i.block_low};
    if (!in_data_i.mode) x = c ^ {sk[3], sk[2], sk[1], sk[0]};
    else x = {c[63:32] ^ sk[5], c[31:0] ^ sk[4], c[127:96] ^ sk[7], c[95:64] ^ sk[6]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) w_valid_q <= 1'b0;
    else if (en) w_valid_q <= in_valid_i && !ks_busy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_mode_q <= in_data_i.mode;
      w_x_q    <= x;
    end
  end

  assign chain[0] = {w_valid_q, w_mode_q, w_x_q};

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
    tf_round_cell #(.RoundIdx(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .beat_i(chain[g]), .sbox_key_i(sbk),
      .k_enc0_i(sk[2*g + 8]), .k_enc1_i(sk[2*g + 9]),
      .k_dec0_i(sk[2*(ROUND_COUNT-1-g) + 8]), .k_dec1_i(sk[2*(ROUND_COUNT-1-g) + 9]),
      .beat_o(chain[g+1])
    );
  end

  always_comb begin
    if (!chain[ROUND_COUNT].mode) begin
      res.result_low  = {chain[ROUND_COUNT].x[127:96] ^ sk[5],
                         chain[ROUND_COUNT].x[95:64] ^ sk[4]};
      res.result_high = {chain[ROUND_COUNT].x[63:32] ^ sk[7],
                         chain[ROUND_COUNT].x[31:0] ^ sk[6]};
    end else begin
      res.result_low  = chain[ROUND_COUNT].x[63:0] ^ {sk[1], sk[0]};
      res.result_high = chain[ROUND_COUNT].x[127:64] ^ {sk[3], sk[2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= chain[ROUND_COUNT].valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_data_o <= res;
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ks_busy |-> in_stall_o) else $error("input taken during key sweep");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && chain[ROUND_COUNT].valid) |=> out_valid_o) else $error("result lost");
`endif
endmodule

>>> verif/tb_twofish_block_cipher.sv
// Self-checking testbench for the Twofish-256 block cipher with random beats and key changes
`timescale 1ns / 1ps
module tb_twofish_block_cipher;
  import tf_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandCount = 550;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  twofish_block_cipher u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #2 clk_i = ~clk_i;

  // testbench copy of the key and its schedule
  logic [63:0] key_reg [4];
  logic [31:0] subkey [SubkeyCount];
  logic [31:0] sbox_key [4];

  in_item_t  pending_blocks [$];
  out_item_t expected_blocks [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit calm = 1'b0;   // no idling on either side
  bit hold = 1'b0;   // sender paused

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b, logic [8:0] poly);
    logic [8:0] t;
    logic [7:0] acc;
    t = {1'b0, a};
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= t[7:0];
      t = t << 1;
      if (t[8]) t ^= poly;
    end
    return acc;
  endfunction

  function automatic logic [7:0] qbox(logic [7:0] x, bit use_b);
    logic [3:0] a, b, a2, b2;
    a = x[7:4];
    b = x[3:0];
    a2 = a ^ b;
    b2 = a ^ {b[0], b[3:1]} ^ {a[0], 3'b0};
    a = use_b ? QbT0[a2] : QaT0[a2];
    b = use_b ? QbT1[b2] : QaT1[b2];
    a2 = a ^ b;
    b2 = a ^ {b[0], b[3:1]} ^ {a[0], 3'b0};
    a = use_b ? QbT2[a2] : QaT2[a2];
    b = use_b ? QbT3[b2] : QaT3[b2];
    return {b, a};
  endfunction

  function automatic logic [31:0] mix_h(logic [31:0] x, logic [31:0] l [4]);
    // q selection per stage (1 = qb), from the key word l[3] down to the last q layer
    bit sel [5][4] = '{'{1,0,0,1}, '{1,1,0,0}, '{0,1,0,1}, '{0,0,1,1}, '{1,0,1,0}};
    logic [7:0] mds [4][4] = '{'{8'h01,8'hEF,8'h5B,8'h5B}, '{8'h5B,8'hEF,8'hEF,8'h01},
                              '{8'hEF,8'h5B,8'h01,8'hEF}, '{8'hEF,8'h01,8'hEF,8'h5B}};
    logic [7:0] y [4];
    logic [7:0] v;
    logic [31:0] z;
    for (int j = 0; j < 4; j++) y[j] = x[8*j +: 8];
    for (int s = 0; s < 4; s++)
      for (int j = 0; j < 4; j++) y[j] = qbox(y[j], sel[s][j]) ^ l[3-s][8*j +: 8];
    for (int j = 0; j < 4; j++) y[j] = qbox(y[j], sel[4][j]);
    z = '0;
    for (int j = 0; j < 4; j++) begin
      v = '0;
      for (int k = 0; k < 4; k++) v ^= gmul(mds[j][k], y[k], MdsPoly);
      z[8*j +: 8] = v;
    end
    return z;
  endfunction

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void schedule_key();
    logic [7:0] rs [4][8] = '{'{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
                             '{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
                             '{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
                             '{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}};
    logic [31:0] ev [4];
    logic [31:0] od [4];
    logic [7:0] acc;
    logic [31:0] a, b;
    for (int i = 0; i < 4; i++) begin
      ev[i] = key_reg[i][31:0];
      od[i] = key_reg[i][63:32];
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int k = 0; k < 8; k++) acc ^= gmul(rs[j][k], key_reg[i][8*k +: 8], RsPoly);
        sbox_key[3-i][8*j +: 8] = acc;
      end
    end
    for (int i = 0; i < SubkeyCount / 2; i++) begin
      a = mix_h(SubkeyStep * (2 * i), ev);
      b = rol(mix_h(SubkeyStep * (2 * i + 1), od), 8);
      subkey[2*i] = a + b;
      subkey[2*i+1] = rol(a + (b << 1), 9);
    end
  endfunction

  function automatic out_item_t cipher_block(in_item_t it);
    logic [31:0] x [4];
    logic [31:0] c [4];
    logic [31:0] t0, t1, f0, f1;
    int s, d;
    out_item_t res;
    c = '{it.block_low[31:0], it.block_low[63:32], it.block_high[31:0], it.block_high[63:32]};
    if (!it.mode) begin
      for (int i = 0; i < 4; i++) x[i] = c[i] ^ subkey[i];
      for (int r = 0; r < RoundCount; r++) begin
        s = r[0] ? 2 : 0;
        d = s ^ 2;
        t0 = mix_h(x[s], sbox_key);
        t1 = mix_h(rol(x[s+1], 8), sbox_key);
        f0 = t0 + t1 + subkey[2*r+8];
        f1 = t0 + (t1 << 1) + subkey[2*r+9];
        x[d] = rol(x[d] ^ f0, 31);
        x[d+1] = rol(x[d+1], 1) ^ f1;
      end
      c = '{x[2] ^ subkey[4], x[3] ^ subkey[5], x[0] ^ subkey[6], x[1] ^ subkey[7]};
    end else begin
      x = '{c[2] ^ subkey[6], c[3] ^ subkey[7], c[0] ^ subkey[4], c[1] ^ subkey[5]};
      for (int r = RoundCount - 1; r >= 0; r--) begin
        s = r[0] ? 2 : 0;
        d = s ^ 2;
        t0 = mix_h(x[s], sbox_key);
        t1 = mix_h(rol(x[s+1], 8), sbox_key);
        f0 = t0 + t1 + subkey[2*r+8];
        f1 = t0 + (t1 << 1) + subkey[2*r+9];
        x[d] = rol(x[d], 1) ^ f0;
        x[d+1] = rol(x[d+1] ^ f1, 31);
      end
      for (int i = 0; i < 4; i++) c[i] = x[i] ^ subkey[i];
    end
    res.result_low = {c[1], c[0]};
    res.result_high = {c[3], c[2]};
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly uniform, sometimes all-zero or all-one halves
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic in_item_t make_block(logic mode, logic [63:0] lo, logic [63:0] hi);
    in_item_t it;
    it.mode = mode;
    it.block_low = lo;
    it.block_high = hi;
    return it;
  endfunction

  function automatic void queue_block(in_item_t it);
    pending_blocks = {pending_blocks, it};
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_blocks = {expected_blocks, cipher_block(in_data_i)};
      void'(pending_blocks.pop_front());
    end
    if ((!in_valid_i || !in_stall_o) && rst_ni) begin
      if (pending_blocks.size() != 0 && !hold && (calm || $urandom_range(0, 99) >= 27)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_blocks[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_data_o);
        errors++;
      end else begin
        if (out_data_o.result_low !== expected_blocks[0].result_low) begin
          $display("%0t: result_low expected %h actual %h", $time,
                   expected_blocks[0].result_low, out_data_o.result_low);
          errors++;
        end
        if (out_data_o.result_high !== expected_blocks[0].result_high) begin
          $display("%0t: result_high expected %h actual %h", $time,
                   expected_blocks[0].result_high, out_data_o.result_high);
          errors++;
        end
        void'(expected_blocks.pop_front());
      end
    end
    out_stall_i <= !calm && $urandom_range(0, 99) < 27;
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_key(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_reg[idx] = val;
    schedule_key();
  endtask

  task automatic drain();
    while (pending_blocks.size() != 0 || in_valid_i || expected_blocks.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    drain();
    write_key(REG_KEY_WORD_0, k0);
    write_key(REG_KEY_WORD_1, k1);
    write_key(REG_KEY_WORD_2, k2);
    write_key(REG_KEY_WORD_3, k3);
  endtask

  initial begin
    out_item_t ct;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    schedule_key();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero key, edge blocks both ways
    queue_block(make_block(1'b0, '0, '0));
    queue_block(make_block(1'b1, '0, '0));
    queue_block(make_block(1'b0, '1, '1));
    queue_block(make_block(1'b1, '1, '1));
    queue_block(make_block(1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    queue_block(make_block(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));

    load_key('1, '1, '1, '1);
    for (int i = 0; i < 4; i++) queue_block(make_block(i[0], pick64(), pick64()));
    load_key(64'hEFCDAB8967452301, 64'h1032547698BADCFE,
             64'h7766554433221100, 64'hFFEEDDCCBBAA9988);
    for (int i = 0; i < 4; i++) begin
      // round trip: encrypt then decrypt its ciphertext
      queue_block(make_block(1'b0, rand64(), rand64()));
      ct = cipher_block(pending_blocks[$]);
      queue_block(make_block(1'b1, ct.result_low, ct.result_high));
    end

    // random phases under random keys, one calm stretch
    for (int ph = 0; ph < 5; ph++) begin
      load_key(pick64(), pick64(), pick64(), pick64());
      calm = (ph == 2);
      for (int i = 0; i < RandCount / 5; i++)
        queue_block(make_block(1'($urandom_range(0, 1)), pick64(), pick64()));
      if (ph == 3) begin
        while (pending_blocks.size() > RandCount / 10) @(posedge clk_i);
        hold = 1'b1;
        while (in_valid_i || expected_blocks.size() != 0) @(posedge clk_i);
        hold = 1'b0;
      end
    end
    calm = 1'b0;
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
